// ===== design/m6805_alu_pkg.sv =====
// Shared types and constants for the 6805 ALU execute block.
// No dependencies; imported by the interfaces and every module of the block.
`timescale 1ns / 1ps

package m6805_alu_pkg;

    localparam int W_BYTE = 8;
    localparam int W_OP   = 4;
    localparam int W_CC   = 5;
    localparam int W_GRP  = 2;

    // Condition code bit positions.
    localparam int CC_C_BIT = 0;
    localparam int CC_Z_BIT = 1;
    localparam int CC_N_BIT = 2;
    localparam int CC_I_BIT = 3;
    localparam int CC_H_BIT = 4;

    typedef enum logic [W_GRP-1:0] {
        GRP_RMW   = 2'd0,
        GRP_ALU   = 2'd1,
        GRP_MUL   = 2'd2,
        GRP_UNDEF = 2'd3
    } t_grp;

    // Read-modify-write op nibbles.
    localparam logic [W_OP-1:0] RMW_NEG = 4'h0;
    localparam logic [W_OP-1:0] RMW_COM = 4'h3;
    localparam logic [W_OP-1:0] RMW_LSR = 4'h4;
    localparam logic [W_OP-1:0] RMW_ROR = 4'h6;
    localparam logic [W_OP-1:0] RMW_ASR = 4'h7;
    localparam logic [W_OP-1:0] RMW_LSL = 4'h8;
    localparam logic [W_OP-1:0] RMW_ROL = 4'h9;
    localparam logic [W_OP-1:0] RMW_DEC = 4'hA;
    localparam logic [W_OP-1:0] RMW_INC = 4'hC;
    localparam logic [W_OP-1:0] RMW_TST = 4'hD;
    localparam logic [W_OP-1:0] RMW_CLR = 4'hF;

    // Accumulator ALU op nibbles.
    localparam logic [W_OP-1:0] ALU_SUB = 4'h0;
    localparam logic [W_OP-1:0] ALU_CMP = 4'h1;
    localparam logic [W_OP-1:0] ALU_SBC = 4'h2;
    localparam logic [W_OP-1:0] ALU_CPX = 4'h3;
    localparam logic [W_OP-1:0] ALU_AND = 4'h4;
    localparam logic [W_OP-1:0] ALU_BIT = 4'h5;
    localparam logic [W_OP-1:0] ALU_LDA = 4'h6;
    localparam logic [W_OP-1:0] ALU_STA = 4'h7;
    localparam logic [W_OP-1:0] ALU_EOR = 4'h8;
    localparam logic [W_OP-1:0] ALU_ADC = 4'h9;
    localparam logic [W_OP-1:0] ALU_ORA = 4'hA;
    localparam logic [W_OP-1:0] ALU_ADD = 4'hB;
    localparam logic [W_OP-1:0] ALU_LDX = 4'hE;
    localparam logic [W_OP-1:0] ALU_STX = 4'hF;

    typedef struct packed {
        logic [W_GRP-1:0]  req_type;
        logic [W_OP-1:0]   op_code;
        logic [W_BYTE-1:0] acc_in;
        logic [W_BYTE-1:0] index_in;
        logic [W_BYTE-1:0] operand_value;
        logic [W_CC-1:0]   cc_in;
    } t_req;

    typedef struct packed {
        logic [W_BYTE-1:0] acc_out;
        logic [W_BYTE-1:0] index_out;
        logic [W_BYTE-1:0] write_value;
        logic              write_back;
        logic [W_CC-1:0]   cc_out;
        logic              op_defined;
    } t_rsp;

endpackage

// ===== design/m6805_alu_req_if.sv =====
// Request channel of the 6805 ALU execute block: valid/ready plus the request word.
// Depends on m6805_alu_pkg for the field widths.
`timescale 1ns / 1ps

interface m6805_alu_req_if;
    import m6805_alu_pkg::*;

    logic              valid;
    logic              ready;
    logic [W_GRP-1:0]  req_type;
    logic [W_OP-1:0]   op_code;
    logic [W_BYTE-1:0] acc_in;
    logic [W_BYTE-1:0] index_in;
    logic [W_BYTE-1:0] operand_value;
    logic [W_CC-1:0]   cc_in;

    modport source (
        output valid, req_type, op_code, acc_in, index_in, operand_value, cc_in,
        input  ready
    );

    modport sink (
        input  valid, req_type, op_code, acc_in, index_in, operand_value, cc_in,
        output ready
    );
endinterface

// ===== design/m6805_alu_rsp_if.sv =====
// Result channel of the 6805 ALU execute block: valid/ready plus the result word.
// Depends on m6805_alu_pkg for the field widths.
`timescale 1ns / 1ps

interface m6805_alu_rsp_if;
    import m6805_alu_pkg::*;

    logic              valid;
    logic              ready;
    logic [W_BYTE-1:0] acc_out;
    logic [W_BYTE-1:0] index_out;
    logic [W_BYTE-1:0] write_value;
    logic              write_back;
    logic [W_CC-1:0]   cc_out;
    logic              op_defined;

    modport source (
        output valid, acc_out, index_out, write_value, write_back, cc_out, op_defined,
        input  ready
    );

    modport sink (
        input  valid, acc_out, index_out, write_value, write_back, cc_out, op_defined,
        output ready
    );
endinterface

// ===== design/m6805_alu_core.sv =====
// Combinational 6805 ALU: read-modify-write group, accumulator group and multiply.
// Depends on m6805_alu_pkg for the request and result words and the op codes.
`timescale 1ns / 1ps

module m6805_alu_core (
    input  m6805_alu_pkg::t_req i_req,
    output m6805_alu_pkg::t_rsp o_rsp
);
    import m6805_alu_pkg::*;

    logic [W_BYTE-1:0]   a, x, m;
    logic [W_CC-1:0]     cc;
    logic                cin;
    logic [W_BYTE-1:0]   r;
    logic [W_BYTE-1:0]   nz_src;
    logic                nz_upd;
    logic [W_BYTE:0]     sub_a;
    logic [W_BYTE:0]     sub_x;
    logic [W_BYTE:0]     sbc_a;
    logic [W_BYTE:0]     add_a;
    logic [W_OP:0]       add_lo;
    logic [2*W_BYTE-1:0] prod;
    logic                add_cin;

    assign a   = i_req.acc_in;
    assign x   = i_req.index_in;
    assign m   = i_req.operand_value;
    assign cin = i_req.cc_in[CC_C_BIT];

    // ADC takes the carry in, ADD does not.
    assign add_cin = (i_req.op_code == ALU_ADC) ? cin : 1'b0;

    assign sub_a  = {1'b0, a} - {1'b0, m};
    assign sub_x  = {1'b0, x} - {1'b0, m};
    assign sbc_a  = {1'b0, a} - {1'b0, m} - {{W_BYTE{1'b0}}, cin};
    assign add_a  = {1'b0, a} + {1'b0, m} + {{W_BYTE{1'b0}}, add_cin};
    assign add_lo = {1'b0, a[W_OP-1:0]} + {1'b0, m[W_OP-1:0]} + {{W_OP{1'b0}}, add_cin};
    assign prod   = x * a;

    always_comb begin
        o_rsp.acc_out     = a;
        o_rsp.index_out   = x;
        o_rsp.write_value = '0;
        o_rsp.write_back  = 1'b0;
        o_rsp.op_defined  = 1'b1;
        cc                = i_req.cc_in;
        r                 = m;
        nz_src            = '0;
        nz_upd            = 1'b0;

        unique case (t_grp'(i_req.req_type))
            GRP_RMW: begin
                o_rsp.write_back = 1'b1;
                nz_upd           = 1'b1;
                unique case (i_req.op_code)
                    RMW_NEG: begin
                        r            = 8'h00 - m;
                        cc[CC_C_BIT] = (m != 8'h00);
                    end
                    RMW_COM: begin
                        r            = ~m;
                        cc[CC_C_BIT] = 1'b1;
                    end
                    RMW_LSR: begin
                        r            = {1'b0, m[W_BYTE-1:1]};
                        cc[CC_C_BIT] = m[0];
                    end
                    RMW_ROR: begin
                        r            = {cin, m[W_BYTE-1:1]};
                        cc[CC_C_BIT] = m[0];
                    end
                    RMW_ASR: begin
                        r            = {m[W_BYTE-1], m[W_BYTE-1:1]};
                        cc[CC_C_BIT] = m[0];
                    end
                    RMW_LSL: begin
                        r            = {m[W_BYTE-2:0], 1'b0};
                        cc[CC_C_BIT] = m[W_BYTE-1];
                    end
                    RMW_ROL: begin
                        r            = {m[W_BYTE-2:0], cin};
                        cc[CC_C_BIT] = m[W_BYTE-1];
                    end
                    RMW_DEC: r = m - 8'h01;
                    RMW_INC: r = m + 8'h01;
                    RMW_TST: begin
                        // Flags from the operand, nothing stored back.
                        r                = '0;
                        o_rsp.write_back = 1'b0;
                    end
                    RMW_CLR: r = '0;
                    default: begin
                        r                = '0;
                        o_rsp.write_back = 1'b0;
                        o_rsp.op_defined = 1'b0;
                        nz_upd           = 1'b0;
                    end
                endcase
                nz_src            = (i_req.op_code == RMW_TST) ? m : r;
                o_rsp.write_value = r;
            end
            GRP_ALU: begin
                nz_upd = 1'b1;
                unique case (i_req.op_code)
                    ALU_SUB: begin
                        o_rsp.acc_out = sub_a[W_BYTE-1:0];
                        cc[CC_C_BIT]  = sub_a[W_BYTE];
                        nz_src        = sub_a[W_BYTE-1:0];
                    end
                    ALU_CMP: begin
                        cc[CC_C_BIT] = sub_a[W_BYTE];
                        nz_src       = sub_a[W_BYTE-1:0];
                    end
                    ALU_SBC: begin
                        o_rsp.acc_out = sbc_a[W_BYTE-1:0];
                        cc[CC_C_BIT]  = sbc_a[W_BYTE];
                        nz_src        = sbc_a[W_BYTE-1:0];
                    end
                    ALU_CPX: begin
                        cc[CC_C_BIT] = sub_x[W_BYTE];
                        nz_src       = sub_x[W_BYTE-1:0];
                    end
                    ALU_AND: begin
                        o_rsp.acc_out = a & m;
                        nz_src        = a & m;
                    end
                    ALU_BIT: nz_src = a & m;
                    ALU_LDA: begin
                        o_rsp.acc_out = m;
                        nz_src        = m;
                    end
                    ALU_STA: begin
                        o_rsp.write_value = a;
                        o_rsp.write_back  = 1'b1;
                        nz_src            = a;
                    end
                    ALU_EOR: begin
                        o_rsp.acc_out = a ^ m;
                        nz_src        = a ^ m;
                    end
                    ALU_ADC, ALU_ADD: begin
                        o_rsp.acc_out = add_a[W_BYTE-1:0];
                        cc[CC_C_BIT]  = add_a[W_BYTE];
                        cc[CC_H_BIT]  = add_lo[W_OP];
                        nz_src        = add_a[W_BYTE-1:0];
                    end
                    ALU_ORA: begin
                        o_rsp.acc_out = a | m;
                        nz_src        = a | m;
                    end
                    ALU_LDX: begin
                        o_rsp.index_out = m;
                        nz_src          = m;
                    end
                    ALU_STX: begin
                        o_rsp.write_value = x;
                        o_rsp.write_back  = 1'b1;
                        nz_src            = x;
                    end
                    default: begin
                        // JMP and JSR are handled outside the ALU.
                        o_rsp.op_defined = 1'b0;
                        nz_upd           = 1'b0;
                    end
                endcase
            end
            GRP_MUL: begin
                o_rsp.index_out = prod[2*W_BYTE-1:W_BYTE];
                o_rsp.acc_out   = prod[W_BYTE-1:0];
                cc[CC_H_BIT]    = 1'b0;
                cc[CC_C_BIT]    = 1'b0;
            end
            default: o_rsp.op_defined = 1'b0;
        endcase

        if (nz_upd) begin
            cc[CC_N_BIT] = nz_src[W_BYTE-1];
            cc[CC_Z_BIT] = (nz_src == '0);
        end
        o_rsp.cc_out = cc;
    end
endmodule

// ===== design/m6805_alu_execute_top.sv =====
// 6805 ALU execute block: an accepted request word is registered in the request register, and its result
// is offered from the output register; throughput one word per cycle while the result side does not stall.
// The request register feeds the ALU, whose result is held in the output register;
// each stage advances whenever the stage after it is empty or being emptied.
// Reset (synchronous, active low) empties both stages; payload registers are not reset.
// Depends on m6805_alu_pkg, m6805_alu_req_if, m6805_alu_rsp_if and m6805_alu_core.
`timescale 1ns / 1ps

module m6805_alu_execute_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    m6805_alu_req_if.sink          i_req,
    m6805_alu_rsp_if.source        o_rsp
);
    import m6805_alu_pkg::*;

    logic r_s1_vld, n_s1_vld;
    t_req r_s1_req, n_s1_req;
    logic r_s2_vld, n_s2_vld;
    t_rsp r_s2_rsp, n_s2_rsp;
    t_rsp w_alu_rsp;
    logic w_s1_rdy;
    logic w_s2_rdy;

    m6805_alu_core u_core (
        .i_req (r_s1_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_s2_rdy    = !r_s2_vld || o_rsp.ready;
    assign w_s1_rdy    = !r_s1_vld || w_s2_rdy;
    assign i_req.ready = w_s1_rdy;

    always_comb begin
        n_s1_vld = r_s1_vld;
        n_s1_req = r_s1_req;
        n_s2_vld = r_s2_vld;
        n_s2_rsp = r_s2_rsp;
        if (w_s1_rdy) begin
            n_s1_vld = i_req.valid;
            n_s1_req = '{req_type:      i_req.req_type,
                         op_code:       i_req.op_code,
                         acc_in:        i_req.acc_in,
                         index_in:      i_req.index_in,
                         operand_value: i_req.operand_value,
                         cc_in:         i_req.cc_in};
        end
        if (w_s2_rdy) begin
            n_s2_vld = r_s1_vld;
            n_s2_rsp = w_alu_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
        end
        r_s1_req <= n_s1_req;
        r_s2_rsp <= n_s2_rsp;
    end

    assign o_rsp.valid       = r_s2_vld;
    assign o_rsp.acc_out     = r_s2_rsp.acc_out;
    assign o_rsp.index_out   = r_s2_rsp.index_out;
    assign o_rsp.write_value = r_s2_rsp.write_value;
    assign o_rsp.write_back  = r_s2_rsp.write_back;
    assign o_rsp.cc_out      = r_s2_rsp.cc_out;
    assign o_rsp.op_defined  = r_s2_rsp.op_defined;

    // An accepted word always lands in the request register.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_s1_vld)
        else $error("accepted request word was not captured");

    // A request blocked by a full output stage must be kept intact.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !w_s2_rdy |=> r_s1_vld && $stable(r_s1_req))
        else $error("stalled request word was lost or altered");

    // With both stages empty the block must take a new word.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_vld && !r_s2_vld |-> i_req.ready)
        else $error("empty pipeline refused a request word");

    // Undefined operations never ask for a store.
    a_undef_no_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.op_defined |-> !o_rsp.write_back && (o_rsp.write_value == '0))
        else $error("undefined operation requested a write back");
endmodule

// ===== tb/m6805_alu_execute_top_tb.sv =====
// Self-checking testbench for the 6805 ALU execute block (m6805_alu_execute_top).
// Drives request words with random gaps, predicts every result and checks each returned word.
// Depends on m6805_alu_pkg, m6805_alu_req_if, m6805_alu_rsp_if and the block itself.
`timescale 1ns / 1ps

module m6805_alu_execute_top_tb;
    import m6805_alu_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_PRINTED = 30;

    logic i_clk = 1'b0;
    logic i_rst_n;

    m6805_alu_req_if req_if ();
    m6805_alu_rsp_if rsp_if ();

    m6805_alu_execute_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_rsp pending_results[$];
    int   mismatches = 0;
    int   words_checked = 0;
    int   cycles = 0;
    int   src_run = 0;
    bit   src_gaps_on = 1'b1;
    int   sink_wait = 0;
    int   sink_run = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [W_CC-1:0] with_nz(input logic [W_CC-1:0] cc,
                                                input logic [W_BYTE-1:0] v);
        cc[CC_N_BIT] = v[7];
        cc[CC_Z_BIT] = (v == 8'h00);
        return cc;
    endfunction

    function automatic t_rsp alu_execute(input t_req q);
        t_rsp              r;
        logic [W_BYTE-1:0] a, x, m, res;
        logic [W_CC-1:0]   cc;
        logic [8:0]        diff, sum;
        logic [4:0]        half;
        logic [15:0]       prod;
        logic              cin;
        a   = q.acc_in;
        x   = q.index_in;
        m   = q.operand_value;
        cc  = q.cc_in;
        cin = q.cc_in[CC_C_BIT];
        res = m;
        r   = '0;
        r.op_defined = 1'b1;
        case (q.req_type)
            GRP_RMW: begin
                r.write_back = 1'b1;
                case (q.op_code)
                    RMW_NEG: begin
                        res = 8'h00 - m;
                        cc[CC_C_BIT] = (m != 8'h00);
                    end
                    RMW_COM: begin
                        res = ~m;
                        cc[CC_C_BIT] = 1'b1;
                    end
                    RMW_LSR: begin
                        res = {1'b0, m[7:1]};
                        cc[CC_C_BIT] = m[0];
                    end
                    RMW_ROR: begin
                        res = {cin, m[7:1]};
                        cc[CC_C_BIT] = m[0];
                    end
                    RMW_ASR: begin
                        res = {m[7], m[7:1]};
                        cc[CC_C_BIT] = m[0];
                    end
                    RMW_LSL: begin
                        res = {m[6:0], 1'b0};
                        cc[CC_C_BIT] = m[7];
                    end
                    RMW_ROL: begin
                        res = {m[6:0], cin};
                        cc[CC_C_BIT] = m[7];
                    end
                    RMW_DEC: res = m - 8'h01;
                    RMW_INC: res = m + 8'h01;
                    RMW_TST: r.write_back = 1'b0;
                    RMW_CLR: res = 8'h00;
                    default: begin
                        r.op_defined = 1'b0;
                        r.write_back = 1'b0;
                    end
                endcase
                if (r.op_defined)
                    cc = with_nz(cc, res);
                // TST and the holes leave the write data at zero.
                if (r.write_back)
                    r.write_value = res;
            end
            GRP_ALU: begin
                case (q.op_code)
                    ALU_SUB, ALU_SBC: begin
                        if (q.op_code == ALU_SUB)
                            cin = 1'b0;
                        diff = {1'b0, a} - {1'b0, m} - {8'h00, cin};
                        cc[CC_C_BIT] = diff[8];
                        a = diff[7:0];
                        cc = with_nz(cc, a);
                    end
                    ALU_CMP: begin
                        diff = {1'b0, a} - {1'b0, m};
                        cc[CC_C_BIT] = diff[8];
                        cc = with_nz(cc, diff[7:0]);
                    end
                    ALU_CPX: begin
                        diff = {1'b0, x} - {1'b0, m};
                        cc[CC_C_BIT] = diff[8];
                        cc = with_nz(cc, diff[7:0]);
                    end
                    ALU_AND: begin
                        a = a & m;
                        cc = with_nz(cc, a);
                    end
                    ALU_BIT: cc = with_nz(cc, a & m);
                    ALU_LDA: begin
                        a = m;
                        cc = with_nz(cc, a);
                    end
                    ALU_STA: begin
                        r.write_value = a;
                        r.write_back = 1'b1;
                        cc = with_nz(cc, a);
                    end
                    ALU_EOR: begin
                        a = a ^ m;
                        cc = with_nz(cc, a);
                    end
                    ALU_ADC, ALU_ADD: begin
                        if (q.op_code == ALU_ADD)
                            cin = 1'b0;
                        sum  = {1'b0, a} + {1'b0, m} + {8'h00, cin};
                        half = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'h0, cin};
                        cc[CC_H_BIT] = half[4];
                        cc[CC_C_BIT] = sum[8];
                        a = sum[7:0];
                        cc = with_nz(cc, a);
                    end
                    ALU_ORA: begin
                        a = a | m;
                        cc = with_nz(cc, a);
                    end
                    ALU_LDX: begin
                        x = m;
                        cc = with_nz(cc, x);
                    end
                    ALU_STX: begin
                        r.write_value = x;
                        r.write_back = 1'b1;
                        cc = with_nz(cc, x);
                    end
                    default: r.op_defined = 1'b0;
                endcase
            end
            GRP_MUL: begin
                prod = {8'h00, x} * {8'h00, a};
                a = prod[7:0];
                x = prod[15:8];
                cc[CC_H_BIT] = 1'b0;
                cc[CC_C_BIT] = 1'b0;
            end
            default: r.op_defined = 1'b0;
        endcase
        r.acc_out   = a;
        r.index_out = x;
        r.cc_out    = cc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------
    // Mostly short gaps, a few long ones, and now and then a run with none at all.
    function automatic int pick_gap(inout int run_left);
        int r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            run_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [W_BYTE-1:0] pick_byte();
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0: return 8'h00;
                1: return 8'h01;
                2: return 8'h7F;
                3: return 8'h80;
                4: return 8'hFE;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_req random_word();
        t_req w;
        int   r;
        r = $urandom_range(0, 99);
        if (r < 40)
            w.req_type = GRP_RMW;
        else if (r < 85)
            w.req_type = GRP_ALU;
        else if (r < 95)
            w.req_type = GRP_MUL;
        else
            w.req_type = GRP_UNDEF;
        w.op_code       = 4'($urandom_range(0, 15));
        w.acc_in        = pick_byte();
        w.index_in      = pick_byte();
        w.operand_value = pick_byte();
        w.cc_in         = 5'($urandom_range(0, 31));
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_word(input t_req w);
        int gap;
        gap = src_gaps_on ? pick_gap(src_run) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= w.req_type;
        req_if.op_code       <= w.op_code;
        req_if.acc_in        <= w.acc_in;
        req_if.index_in      <= w.index_in;
        req_if.operand_value <= w.operand_value;
        req_if.cc_in         <= w.cc_in;
        do
            @(posedge i_clk);
        while (!req_if.ready);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    // Each accepted request word is turned into its expected result at once.
    always @(posedge i_clk) begin
        t_req q;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            q.req_type      = req_if.req_type;
            q.op_code       = req_if.op_code;
            q.acc_in        = req_if.acc_in;
            q.index_in      = req_if.index_in;
            q.operand_value = req_if.operand_value;
            q.cc_in         = req_if.cc_in;
            pending_results.push_back(alu_execute(q));
        end
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (sink_wait > 0)
            sink_wait--;
        else
            sink_wait = pick_gap(sink_run);
        rsp_if.ready <= (sink_wait == 0);
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch on result word %0d: %s got %0h, expected %0h",
                     words_checked, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.acc_out !== want.acc_out)
                    report_mismatch("acc_out", rsp_if.acc_out, want.acc_out);
                if (rsp_if.index_out !== want.index_out)
                    report_mismatch("index_out", rsp_if.index_out, want.index_out);
                if (rsp_if.write_value !== want.write_value)
                    report_mismatch("write_value", rsp_if.write_value, want.write_value);
                if (rsp_if.write_back !== want.write_back)
                    report_mismatch("write_back", rsp_if.write_back, want.write_back);
                if (rsp_if.cc_out !== want.cc_out)
                    report_mismatch("cc_out", rsp_if.cc_out, want.cc_out);
                if (rsp_if.op_defined !== want.op_defined)
                    report_mismatch("op_defined", rsp_if.op_defined, want.op_defined);
            end
            words_checked++;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every nibble of both op groups, holes, JMP and JSR included, with corner operands.
    task automatic test_op_sweep();
        t_req w;
        for (int op = 0; op < 16; op++) begin
            w.req_type = GRP_RMW;
            w.op_code  = 4'(op);
            w.acc_in   = 8'h5A;
            w.index_in = 8'hA5;
            case (op % 4)
                0: w.operand_value = 8'h00;
                1: w.operand_value = 8'h80;
                2: w.operand_value = 8'hFF;
                default: w.operand_value = 8'h01;
            endcase
            w.cc_in = op[0] ? 5'h1F : 5'h00;
            send_word(w);
        end
        for (int op = 0; op < 16; op++) begin
            w.req_type      = GRP_ALU;
            w.op_code       = 4'(op);
            w.acc_in        = op[0] ? 8'hFF : 8'h0F;
            w.index_in      = op[1] ? 8'h80 : 8'h00;
            w.operand_value = op[1] ? 8'h01 : 8'h80;
            w.cc_in         = op[2] ? 5'h1F : 5'h00;
            send_word(w);
        end
        w.req_type      = GRP_MUL;
        w.op_code       = ALU_SUB;
        w.acc_in        = 8'hFF;
        w.index_in      = 8'hFF;
        w.operand_value = 8'h00;
        w.cc_in         = 5'h1F;
        send_word(w);
        w.req_type = GRP_UNDEF;
        w.acc_in   = 8'h12;
        w.index_in = 8'h34;
        w.cc_in    = 5'h15;
        send_word(w);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
            send_word(random_word());
    endtask

    // The sender holds off until the pipeline has returned every result.
    task automatic test_drain_pause();
        test_random_mix(100);
        wait_drained();
        test_random_mix(100);
    endtask

    task automatic test_back_to_back();
        src_gaps_on = 1'b0;
        test_random_mix(400);
        src_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.req_type      <= '0;
        req_if.op_code       <= '0;
        req_if.acc_in        <= '0;
        req_if.index_in      <= '0;
        req_if.operand_value <= '0;
        req_if.cc_in         <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_op_sweep();
        test_random_mix(1220);
        test_drain_pause();
        test_back_to_back();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== m6805_alu_execute_top.f =====
design/m6805_alu_pkg.sv
design/m6805_alu_req_if.sv
design/m6805_alu_rsp_if.sv
design/m6805_alu_core.sv
design/m6805_alu_execute_top.sv
tb/m6805_alu_execute_top_tb.sv
